FILE: hdl/rsa_key_derivation_macros.svh
// ----------------------------------------------------------------------------
// RSA key derivation assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RSA_KEY_DERIVATION_MACROS_SVH
`define RSA_KEY_DERIVATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rkd assertion failed");

// Next-cycle implication, disabled during reset.
`define RKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rkd assertion failed");

// Next-cycle implication that is also checked across reset.
`define RKD_ASSERT_NEXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rkd assertion failed");

`endif

FILE: hdl/rkd_pkg.sv
// ----------------------------------------------------------------------------
// RSA key derivation package
// Widths and status codes shared by the key derivation modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rkd_pkg;

  localparam int PRIME_BITS = 16;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(DATA_W + 1);

  typedef logic [PRIME_BITS-1:0] prime_t;
  typedef logic [DATA_W-1:0]     word_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOPRIME = 2'd1,
    STATUS_NOEXP   = 2'd2
  } status_t;

  // Divider control handshake.
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
    word_t rem;
  } div_rsp_t;

endpackage

FILE: hdl/rkd_div.sv
// ----------------------------------------------------------------------------
// RKD shared divider
// Restoring radix-2 divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rkd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rkd_pkg::div_req_t req,
  output rkd_pkg::div_rsp_t rsp
);
  import rkd_pkg::*;

  logic [DATA_W:0]   part_r;
  word_t             quo_r;
  word_t             den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {part_r[DATA_W-1:0], quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DATA_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      part_r <= '0;
      quo_r  <= req.dividend;
      den_r  <= req.divisor;
    end else if (busy_r) begin
      // Quotient bits shift in at the bottom as dividend bits leave the top.
      if (!diff[DATA_W]) begin
        part_r <= diff;
        quo_r  <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        part_r <= shifted;
        quo_r  <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = part_r[DATA_W-1:0];

endmodule

FILE: hdl/rsa_key_derivation.sv
// ----------------------------------------------------------------------------
// RSA key derivation
// Derives modulus, totient and an exponent pair from two candidate primes.
// ----------------------------------------------------------------------------
// Usage: one input transaction on the in_ stream carries the candidates p and
// q. The block checks both by trial division from 2 up to floor(sqrt(x)),
// forms n = p*q and phi = (p-1)*(q-1), picks the smallest e >= 2 coprime to
// phi by Euclid's algorithm, and solves d = (k*phi+1)/e for the smallest k.
// Exactly one result transaction leaves on the out_ stream per input.
// Every modulo and division goes through one shared restoring divider that
// forms all 32 quotient bits and then raises a registered done flag; a single
// 16x16 multiplier forms n, phi and squares.
// Run time grows with the trial divisions, gcd steps and k steps; two primes
// near 65535 need roughly 500 trial divisions, small inputs far fewer.
// in_tready is high only while the block is idle; one item is in work at a
// time. The result stays on out_tdata with out_tvalid high until the
// receiver takes it, and the next input is taken only after that.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// out_tvalid; no stored data needs clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsa_key_derivation (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [15:0] prime_a, [31:16] prime_b
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata   // [1:0] status, [33:2] modulus,
                                   // [65:34] totient, [97:66] public_exp,
                                   // [129:98] private_exp, rest zero
);
  import rkd_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MULN   = 12'b0000_0000_0010,
    S_MULPHI = 12'b0000_0000_0100,
    S_PSQ    = 12'b0000_0000_1000,
    S_PCHK   = 12'b0000_0001_0000,
    S_PWAIT  = 12'b0000_0010_0000,
    S_ECHK   = 12'b0000_0100_0000,
    S_GWAIT  = 12'b0000_1000_0000,
    S_QWAIT  = 12'b0001_0000_0000,
    S_KCHK   = 12'b0010_0000_0000,
    S_KWAIT  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t   state_r, state_nxt;
  prime_t   p_r, q_r, dv_r;
  logic     sel_r;
  word_t    n_r, phi_r, sq_r;
  word_t    b_r, cand_r;
  word_t    quo_r, rem_e_r, t_r, kq_r, k_r;
  word_t    e_r, d_r;
  status_t  status_r;

  prime_t   mul_a, mul_b;
  word_t    mul_res;
  word_t    x_cur;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);

  // Candidate under the current primality test.
  assign x_cur = sel_r ? word_t'(q_r) : word_t'(p_r);

  // Shared multiplier: n, then phi, then divisor squares.
  always_comb begin
    unique case (state_r)
      S_MULN: begin
        mul_a = p_r;
        mul_b = q_r;
      end
      S_MULPHI: begin
        mul_a = (p_r != '0) ? p_r - 1'b1 : '0;
        mul_b = (q_r != '0) ? q_r - 1'b1 : '0;
      end
      default: begin
        mul_a = dv_r;
        mul_b = dv_r;
      end
    endcase
  end
  assign mul_res = word_t'(mul_a) * word_t'(mul_b);

  // Divider launches.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_PCHK: begin
        if (x_cur >= word_t'(2) && sq_r <= x_cur) begin
          div_req.start    = 1'b1;
          div_req.dividend = x_cur;
          div_req.divisor  = word_t'(dv_r);
        end
      end
      S_ECHK: begin
        if (cand_r < phi_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = phi_r;
          div_req.divisor  = cand_r;
        end
      end
      S_GWAIT: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          if (div_rsp.rem == '0) begin
            // gcd found; when it is one, split phi by e for the k search.
            div_req.start    = (b_r == word_t'(1));
            div_req.dividend = phi_r;
            div_req.divisor  = cand_r;
          end else begin
            div_req.dividend = b_r;
            div_req.divisor  = div_rsp.rem;
          end
        end
      end
      S_KCHK: begin
        if (k_r < e_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = t_r;
          div_req.divisor  = e_r;
        end
      end
      default: div_req = '0;
    endcase
  end

  rkd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_MULN;
      S_MULN:   state_nxt = S_MULPHI;
      S_MULPHI: state_nxt = S_PSQ;
      S_PSQ:    state_nxt = S_PCHK;
      S_PCHK: begin
        if (x_cur < word_t'(2)) begin
          state_nxt = S_DONE;
        end else if (sq_r > x_cur) begin
          state_nxt = sel_r ? S_ECHK : S_PSQ;
        end else begin
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (div_rsp.done) state_nxt = (div_rsp.rem == '0) ? S_DONE : S_PSQ;
      end
      S_ECHK:   state_nxt = (cand_r < phi_r) ? S_GWAIT : S_DONE;
      S_GWAIT: begin
        if (div_rsp.done && div_rsp.rem == '0) begin
          state_nxt = (b_r == word_t'(1)) ? S_QWAIT : S_ECHK;
        end
      end
      S_QWAIT:  if (div_rsp.done) state_nxt = S_KCHK;
      S_KCHK:   state_nxt = (k_r < e_r) ? S_KWAIT : S_DONE;
      S_KWAIT: begin
        if (div_rsp.done) state_nxt = (div_rsp.rem == '0) ? S_DONE : S_KCHK;
      end
      S_DONE:   if (out_acc) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          p_r      <= in_tdata[PRIME_BITS-1:0];
          q_r      <= in_tdata[16 +: PRIME_BITS];
          status_r <= STATUS_OK;
          e_r      <= '0;
          d_r      <= '0;
        end
      end
      S_MULN: n_r <= mul_res;
      S_MULPHI: begin
        phi_r <= mul_res;
        sel_r <= 1'b0;
        dv_r  <= prime_t'(2);
      end
      S_PSQ: sq_r <= mul_res;
      S_PCHK: begin
        if (x_cur < word_t'(2)) begin
          status_r <= STATUS_NOPRIME;
        end else if (sq_r > x_cur) begin
          sel_r  <= 1'b1;
          dv_r   <= prime_t'(2);
          cand_r <= word_t'(2);
        end
      end
      S_PWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) status_r <= STATUS_NOPRIME;
          dv_r <= dv_r + 1'b1;
        end
      end
      S_ECHK: begin
        if (cand_r < phi_r) begin
          b_r <= cand_r;
        end else begin
          status_r <= STATUS_NOEXP;
        end
      end
      S_GWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != '0) begin
            b_r <= div_rsp.rem;
          end else if (b_r == word_t'(1)) begin
            e_r <= cand_r;
          end else begin
            cand_r <= cand_r + 1'b1;
          end
        end
      end
      S_QWAIT: begin
        if (div_rsp.done) begin
          quo_r   <= div_rsp.quo;
          rem_e_r <= div_rsp.rem;
          t_r     <= div_rsp.rem + 1'b1;
          kq_r    <= div_rsp.quo;
          k_r     <= word_t'(1);
        end
      end
      S_KWAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            d_r <= kq_r + div_rsp.quo;
          end else begin
            // Step k by one without a multiply.
            t_r  <= t_r + rem_e_r;
            kq_r <= kq_r + quo_r;
            k_r  <= k_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tdata = {6'd0, d_r, e_r, phi_r, n_r, status_r};

endmodule

FILE: hdl/rkd_checker.sv
// ----------------------------------------------------------------------------
// RKD port checker
// Port-level temporal checks for the RSA key derivation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rsa_key_derivation_macros.svh"

module rkd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  // A held result must not change.
  `RKD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // Right after an item is taken, the block is busy and holds no result.
  `RKD_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready && !out_tvalid)

  // Any error status carries zero exponents.
  `RKD_ASSERT_NOW(a_err_zero, clk, rst_n, out_tvalid && out_tdata[1:0] != 2'd0,
                  out_tdata[129:66] == 64'd0)

  // Reset leaves no result pending.
  `RKD_ASSERT_NEXT_ALL(a_reset, clk, !rst_n, !out_tvalid)

endmodule

bind rsa_key_derivation rkd_checker u_rkd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// RSA key derivation testbench
// Drives candidate prime pairs on the input stream and checks every result
// transaction against typed-in expected values or a behavioral predictor, with
// random idling on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rkd_pkg::*;

  typedef struct {
    status_t status;
    word_t   modulus;
    word_t   totient;
    word_t   public_exp;
    word_t   private_exp;
  } key_set_t;

  typedef struct {
    prime_t   p;
    prime_t   q;
    bit       known;   // expected result typed into the table
    key_set_t keys;
  } pair_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;

  key_set_t  pending_keys[$];
  pair_row_t pair_table[$];
  int        error_count = 0;
  bit        calm = 0;         // stretch with no idling on either side

  rsa_key_derivation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Trial division from 2 up to floor(sqrt(x)); 0 and 1 are not prime.
  function automatic bit is_prime_val(longint unsigned x);
    longint unsigned dv;
    if (x < 2) return 0;
    for (dv = 2; dv * dv <= x; dv++) begin
      if (x % dv == 0) return 0;
    end
    return 1;
  endfunction

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Derives the key set that the block should report for one pair.
  function automatic key_set_t derive_keys(prime_t p, prime_t q);
    key_set_t        r;
    longint unsigned pv, qv, phi, e, k, quo, rem;
    bit              found;
    pv = p;
    qv = q;
    phi = (pv > 0 ? pv - 1 : 0) * (qv > 0 ? qv - 1 : 0);
    r.status = STATUS_OK;
    r.modulus = word_t'(pv * qv);
    r.totient = word_t'(phi);
    r.public_exp = '0;
    r.private_exp = '0;
    if (!is_prime_val(pv) || !is_prime_val(qv)) begin
      r.status = STATUS_NOPRIME;
    end else begin
      found = 0;
      for (e = 2; e < phi; e++) begin
        if (gcd_of(e, phi) == 1) begin
          found = 1;
          break;
        end
      end
      if (!found) begin
        r.status = STATUS_NOEXP;
      end else begin
        // Solve k*phi + 1 = 0 mod e, then divide in two parts to stay exact.
        quo = phi / e;
        rem = phi % e;
        r.public_exp = word_t'(e);
        for (k = 1; k < e; k++) begin
          if ((k * rem + 1) % e == 0) begin
            r.private_exp = word_t'(k * quo + (k * rem + 1) / e);
            break;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic pair_row_t row(prime_t p, prime_t q, bit known = 0,
                                    status_t s = STATUS_OK, word_t e = 0, word_t d = 0);
    pair_row_t r;
    r.p = p;
    r.q = q;
    r.known = known;
    r.keys.status = s;
    r.keys.modulus = word_t'(32'(p) * 32'(q));
    r.keys.totient = word_t'((p > 0 ? 32'(p) - 1 : 0) * (q > 0 ? 32'(q) - 1 : 0));
    r.keys.public_exp = e;
    r.keys.private_exp = d;
    return r;
  endfunction

  function automatic prime_t rand_prime(int hi);
    prime_t x;
    do x = prime_t'($urandom_range(2, hi)); while (!is_prime_val(x));
    return x;
  endfunction

  // Directed rows: extremes, inputs below two, small totient and ordinary keys.
  initial begin
    pair_table = {pair_table, row(0, 0, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(1, 7, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(7, 1, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(0, 65535, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(65535, 65535, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(4, 9, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(2, 2, 1, STATUS_NOEXP)};
    pair_table = {pair_table, row(2, 3, 1, STATUS_NOEXP)};
    pair_table = {pair_table, row(3, 2, 1, STATUS_NOEXP)};
    pair_table = {pair_table, row(3, 3, 1, STATUS_OK, 3, 3)};
    pair_table = {pair_table, row(61, 53)};
    pair_table = {pair_table, row(65521, 65521)};
    pair_table = {pair_table, row(65521, 2)};
    pair_table = {pair_table, row(32749, 65519)};
    pair_table = {pair_table, row(65521, 65534, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(16'h8000, 16'h7fff, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(16'haaab, 16'h5555, 1, STATUS_NOPRIME)};
    pair_table = {pair_table, row(11, 13)};
  end

  // Input side: one transaction at a time, idling now and then.
  initial begin
    pair_row_t r;
    key_set_t  want_keys;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 168; i++) begin
      if (i < pair_table.size()) begin
        r = pair_table[i];
      end else begin
        // Mostly prime pairs, mostly small; some big and some random noise.
        case ($urandom_range(0, 9))
          0, 1:    r = row(prime_t'($urandom), prime_t'($urandom));
          2:       r = row(rand_prime(65535), rand_prime(65535));
          default: r = row(rand_prime(300), rand_prime(300));
        endcase
        r.known = 0;
      end
      calm = (i >= 60 && i < 90);
      while (!calm && $urandom_range(0, 99) < 16) @(posedge clk);
      want_keys = r.known ? r.keys : derive_keys(r.p, r.q);
      pending_keys = {pending_keys, want_keys};
      in_tvalid <= 1'b1;
      in_tdata <= {r.q, r.p};
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Output side: stalls at random, checks each accepted result field by field.
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    key_set_t want;
    out_tready <= calm || ($urandom_range(0, 99) >= 16);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_keys.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[33:2], 0);
      end else begin
        want = pending_keys.pop_front();
        if (out_tdata[1:0] != want.status)
          report_mismatch("status", out_tdata[1:0], want.status);
        if (out_tdata[33:2] != want.modulus)
          report_mismatch("modulus", out_tdata[33:2], want.modulus);
        if (out_tdata[65:34] != want.totient)
          report_mismatch("totient", out_tdata[65:34], want.totient);
        if (out_tdata[97:66] != want.public_exp)
          report_mismatch("public_exp", out_tdata[97:66], want.public_exp);
        if (out_tdata[129:98] != want.private_exp)
          report_mismatch("private_exp", out_tdata[129:98], want.private_exp);
      end
    end
  end

  // Even if every item were as slow as a pair of big primes, the whole run
  // stays far below this limit.
  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
